// ===== design/csvs_pkg.sv =====
// ----------------------------------------------------------------------------
// csvs_pkg
// Shared widths, constants and register indexes for the corrected speed
// vane schedule.
// ----------------------------------------------------------------------------
package csvs_pkg;

    localparam int SPEED_W = 17;
    localparam int TEMP_W  = 16;
    localparam int BREAK_W = 19;
    localparam int ANGLE_W = 16;
    localparam int CFG_W   = 19;
    localparam int IDX_W   = 2;

    // Temperature path: D = 50*T, floor reference 92208
    localparam int DEN_W   = 22;
    localparam logic [DEN_W-1:0] REF_DEN_X10 = DEN_W'(92208);
    // Numerator: 4 * S^2 * 922080
    localparam int SQ_W    = 2 * SPEED_W;
    localparam int NUM_W   = 56;
    localparam int SCALE_W = 22;
    localparam logic [SCALE_W-1:0] NUM_SCALE4 = SCALE_W'(3688320);

    // Ratio quotient and its square root
    localparam int RATIO_W = 40;
    localparam int ROOT_W  = RATIO_W / 2;

    // Interpolation divide
    localparam int SPAN_W  = ANGLE_W + 1;
    localparam int PROD_W  = SPAN_W + BREAK_W;
    localparam int IDEN_W  = BREAK_W + 1;
    localparam int IQ_W    = SPAN_W;

    localparam logic [BREAK_W-1:0] LOW_BREAK_RST  = BREAK_W'(15000);
    localparam logic [BREAK_W-1:0] HIGH_BREAK_RST = BREAK_W'(90000);
    localparam logic [ANGLE_W-1:0] CLOSED_RST     = ANGLE_W'(7680);
    localparam logic [ANGLE_W-1:0] OPEN_RST       = 16'hF100;

    typedef enum logic [IDX_W-1:0] {
        REG_LOW_BREAK  = 2'd0,
        REG_HIGH_BREAK = 2'd1,
        REG_CLOSED     = 2'd2,
        REG_OPEN       = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        SEL_CLOSED = 2'd0,
        SEL_OPEN   = 2'd1,
        SEL_INTERP = 2'd2
    } angle_sel_t;

endpackage

// ===== design/csvs_sample_if.sv =====
// ----------------------------------------------------------------------------
// csvs_sample_if
// Input channel: shaft speed and inlet temperature.
// ----------------------------------------------------------------------------
interface csvs_sample_if;
    import csvs_pkg::*;

    logic               valid;
    logic               ready;
    logic [SPEED_W-1:0] shaft_speed;
    logic [TEMP_W-1:0]  inlet_temp;

    modport source (output valid, shaft_speed, inlet_temp, input ready);
    modport sink   (input valid, shaft_speed, inlet_temp, output ready);
endinterface

// ===== design/csvs_result_if.sv =====
// ----------------------------------------------------------------------------
// csvs_result_if
// Output channel: vane angle, corrected speed and floor flag.
// ----------------------------------------------------------------------------
interface csvs_result_if;
    import csvs_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [ANGLE_W-1:0] vane_angle;
    logic [BREAK_W-1:0]        corrected_speed;
    logic                      theta_floored;

    modport source (output valid, vane_angle, corrected_speed, theta_floored, input ready);
    modport sink   (input valid, vane_angle, corrected_speed, theta_floored, output ready);
endinterface

// ===== design/csvs_div_stage.sv =====
// ----------------------------------------------------------------------------
// csvs_div_stage
// One restoring division step: one quotient bit per stage, MSB first.
// ----------------------------------------------------------------------------
module csvs_div_stage #(
    parameter int DW = 22,
    parameter int QW = 40,
    parameter int SW = 1
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           valid_in,
    input  logic [DW+QW:0] work_in,
    input  logic [DW-1:0]  div_in,
    input  logic [SW-1:0]  side_in,
    output logic           valid_reg,
    output logic [DW+QW:0] work_reg,
    output logic [DW-1:0]  div_reg,
    output logic [SW-1:0]  side_reg
);
    // work = {remainder, numerator bits still to go / quotient bits so far}
    logic [DW:0]    rem_shift;
    logic [DW+1:0]  trial;
    logic           borrow;
    logic [DW+QW:0] work_next;

    always_comb
    begin
        rem_shift = {work_in[DW+QW-1:QW], work_in[QW-1]};
        trial     = {1'b0, rem_shift} - {2'b00, div_in};
        borrow    = trial[DW+1];
        work_next = {(borrow ? rem_shift : trial[DW:0]), work_in[QW-2:0], ~borrow};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            work_reg <= work_next;
            div_reg  <= div_in;
            side_reg <= side_in;
        end
    end
endmodule

// ===== design/csvs_sqrt_stage.sv =====
// ----------------------------------------------------------------------------
// csvs_sqrt_stage
// One restoring square root step: one root bit per stage, two radicand bits.
// ----------------------------------------------------------------------------
module csvs_sqrt_stage #(
    parameter int RW = 20,
    parameter int SW = 1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            valid_in,
    input  logic [2*RW-1:0] rad_in,
    input  logic [RW+1:0]   rem_in,
    input  logic [RW-1:0]   root_in,
    input  logic [SW-1:0]   side_in,
    output logic            valid_reg,
    output logic [2*RW-1:0] rad_reg,
    output logic [RW+1:0]   rem_reg,
    output logic [RW-1:0]   root_reg,
    output logic [SW-1:0]   side_reg
);
    logic [RW+3:0] rem_shift;
    logic [RW+4:0] trial;
    logic          borrow;
    logic [RW+1:0] rem_next;
    logic [RW-1:0] root_next;

    always_comb
    begin
        rem_shift = {rem_in, rad_in[2*RW-1:2*RW-2]};
        trial     = {1'b0, rem_shift} - {3'b000, root_in, 2'b01};
        borrow    = trial[RW+4];
        rem_next  = borrow ? rem_shift[RW+1:0] : trial[RW+1:0];
        root_next = {root_in[RW-2:0], ~borrow};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg  <= {rad_in[2*RW-3:0], 2'b00};
            rem_reg  <= rem_next;
            root_reg <= root_next;
            side_reg <= side_in;
        end
    end
endmodule

// ===== design/corrected_speed_vane_schedule_unit.sv =====
// ----------------------------------------------------------------------------
// corrected_speed_vane_schedule_unit
// Corrected speed from shaft speed and inlet temperature, then a linear
// vane angle schedule between two speed breakpoints.
// ----------------------------------------------------------------------------
//  channel   role   handshake      payload
//  sample    sink   valid/ready    shaft_speed, inlet_temp
//  result    source valid/ready    vane_angle, corrected_speed, theta_floored
//  cfg       write  cfg_we         cfg_index, cfg_data
//
//  One transaction per cycle while the result is not stalled; the
//  40-step ratio divider, the 20-step square root and the 17-step
//  interpolation divider each produce one bit per stage.
//  Reset clears valid bits and loads the register defaults.
//  A stalled result holds the whole pipeline; sample.ready follows it.
// ----------------------------------------------------------------------------
module corrected_speed_vane_schedule_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [csvs_pkg::IDX_W-1:0]       cfg_index,
    input  logic [csvs_pkg::CFG_W-1:0]       cfg_data,
    csvs_sample_if.sink                      sample,
    csvs_result_if.source                    result
);
    import csvs_pkg::*;

    localparam int D1_W = DEN_W + 1 + RATIO_W;
    localparam int D2_W = IDEN_W + 1 + IQ_W;
    localparam int SIDE2_W = BREAK_W + 1 + 2 + 1;

    // configuration registers
    logic [BREAK_W-1:0]        low_break_reg;
    logic [BREAK_W-1:0]        high_break_reg;
    logic signed [ANGLE_W-1:0] closed_reg;
    logic signed [ANGLE_W-1:0] open_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_break_reg  <= LOW_BREAK_RST;
            high_break_reg <= HIGH_BREAK_RST;
            closed_reg     <= CLOSED_RST;
            open_reg       <= OPEN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                REG_LOW_BREAK:  low_break_reg  <= cfg_data[BREAK_W-1:0];
                REG_HIGH_BREAK: high_break_reg <= cfg_data[BREAK_W-1:0];
                REG_CLOSED:     closed_reg     <= cfg_data[ANGLE_W-1:0];
                REG_OPEN:       open_reg       <= cfg_data[ANGLE_W-1:0];
                default:        ;
            endcase
        end
    end

    logic adv;
    logic out_valid_reg;

    assign adv          = !out_valid_reg || result.ready;
    assign sample.ready = adv;

    // stage A: floor check and speed square
    logic [DEN_W-1:0]  den_full;
    logic              a_valid_reg;
    logic [SQ_W-1:0]   a_sq_reg;
    logic [DEN_W-1:0]  a_den_reg;
    logic              a_floor_reg;
    logic              floor_now;

    always_comb
    begin
        den_full  = DEN_W'(sample.inlet_temp) * DEN_W'(50);
        floor_now = den_full < REF_DEN_X10;
    end

    // stage B: numerator scale
    logic              b_valid_reg;
    logic [NUM_W-1:0]  b_num_reg;
    logic [DEN_W-1:0]  b_den_reg;
    logic              b_floor_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= sample.valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_sq_reg    <= SQ_W'(sample.shaft_speed) * SQ_W'(sample.shaft_speed);
            a_den_reg   <= floor_now ? REF_DEN_X10 : den_full;
            a_floor_reg <= floor_now;
            b_num_reg   <= NUM_W'(a_sq_reg) * NUM_W'(NUM_SCALE4);
            b_den_reg   <= a_den_reg;
            b_floor_reg <= a_floor_reg;
        end
    end

    // ratio divider chain: Q = floor(N / D)
    logic              d1_valid [0:RATIO_W];
    logic [D1_W-1:0]   d1_work  [0:RATIO_W];
    logic [DEN_W-1:0]  d1_div   [0:RATIO_W];
    logic [0:0]        d1_side  [0:RATIO_W];

    assign d1_valid[0] = b_valid_reg;
    assign d1_work[0]  = D1_W'(b_num_reg);
    assign d1_div[0]   = b_den_reg;
    assign d1_side[0]  = b_floor_reg;

    for (genvar i = 0; i < RATIO_W; i++)
    begin : g_div1
        csvs_div_stage #(.DW(DEN_W), .QW(RATIO_W), .SW(1)) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .valid_in  (d1_valid[i]),
            .work_in   (d1_work[i]),
            .div_in    (d1_div[i]),
            .side_in   (d1_side[i]),
            .valid_reg (d1_valid[i+1]),
            .work_reg  (d1_work[i+1]),
            .div_reg   (d1_div[i+1]),
            .side_reg  (d1_side[i+1])
        );
    end

    // square root chain on Q
    logic              sq_valid [0:ROOT_W];
    logic [RATIO_W-1:0] sq_rad  [0:ROOT_W];
    logic [ROOT_W+1:0] sq_rem   [0:ROOT_W];
    logic [ROOT_W-1:0] sq_root  [0:ROOT_W];
    logic [0:0]        sq_side  [0:ROOT_W];

    assign sq_valid[0] = d1_valid[RATIO_W];
    assign sq_rad[0]   = d1_work[RATIO_W][RATIO_W-1:0];
    assign sq_rem[0]   = '0;
    assign sq_root[0]  = '0;
    assign sq_side[0]  = d1_side[RATIO_W];

    for (genvar j = 0; j < ROOT_W; j++)
    begin : g_sqrt
        csvs_sqrt_stage #(.RW(ROOT_W), .SW(1)) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .valid_in  (sq_valid[j]),
            .rad_in    (sq_rad[j]),
            .rem_in    (sq_rem[j]),
            .root_in   (sq_root[j]),
            .side_in   (sq_side[j]),
            .valid_reg (sq_valid[j+1]),
            .rad_reg   (sq_rad[j+1]),
            .rem_reg   (sq_rem[j+1]),
            .root_reg  (sq_root[j+1]),
            .side_reg  (sq_side[j+1])
        );
    end

    // stage C: round root to corrected speed, classify against breakpoints
    logic [ROOT_W:0]           root_inc;
    logic [BREAK_W-1:0]        corr;
    logic signed [SPAN_W-1:0]  span;
    angle_sel_t                sel_now;

    logic                      c_valid_reg;
    logic [BREAK_W-1:0]        c_corr_reg;
    logic                      c_floor_reg;
    angle_sel_t                c_sel_reg;
    logic                      c_neg_reg;
    logic [SPAN_W-1:0]         c_mag_reg;
    logic [BREAK_W-1:0]        c_diff_reg;
    logic [BREAK_W-1:0]        c_range_reg;

    always_comb
    begin
        // largest odd k <= root gives c = (root + 1) / 2
        root_inc = {1'b0, sq_root[ROOT_W]} + (ROOT_W+1)'(1);
        corr     = BREAK_W'(root_inc[ROOT_W:1]);
        span     = SPAN_W'(open_reg) - SPAN_W'(closed_reg);
        if (corr <= low_break_reg)
        begin
            sel_now = SEL_CLOSED;
        end
        else if (corr >= high_break_reg)
        begin
            sel_now = SEL_OPEN;
        end
        else
        begin
            sel_now = SEL_INTERP;
        end
    end

    // stage D: product and rounding offset
    logic [PROD_W-1:0]  prod;
    logic               d_valid_reg;
    logic [D2_W-1:0]    d_work_reg;
    logic [IDEN_W-1:0]  d_div_reg;
    logic [SIDE2_W-1:0] d_side_reg;
    logic [PROD_W:0]    num2;

    always_comb
    begin
        prod = PROD_W'(c_mag_reg) * PROD_W'(c_diff_reg);
        num2 = {prod, 1'b0} + (PROD_W+1)'(c_range_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            c_valid_reg <= sq_valid[ROOT_W];
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_corr_reg  <= corr;
            c_floor_reg <= sq_side[ROOT_W][0];
            c_sel_reg   <= sel_now;
            c_neg_reg   <= span[SPAN_W-1];
            c_mag_reg   <= span[SPAN_W-1] ? SPAN_W'(-span) : SPAN_W'(span);
            c_diff_reg  <= corr - low_break_reg;
            c_range_reg <= high_break_reg - low_break_reg;
            // outside the interpolation band divide zero by one
            if (c_sel_reg == SEL_INTERP)
            begin
                d_work_reg <= {1'b0, num2};
                d_div_reg  <= {c_range_reg, 1'b0};
            end
            else
            begin
                d_work_reg <= '0;
                d_div_reg  <= IDEN_W'(1);
            end
            d_side_reg <= {c_corr_reg, c_floor_reg, c_sel_reg, c_neg_reg};
        end
    end

    // interpolation divider chain
    logic               d2_valid [0:IQ_W];
    logic [D2_W-1:0]    d2_work  [0:IQ_W];
    logic [IDEN_W-1:0]  d2_div   [0:IQ_W];
    logic [SIDE2_W-1:0] d2_side  [0:IQ_W];

    assign d2_valid[0] = d_valid_reg;
    assign d2_work[0]  = d_work_reg;
    assign d2_div[0]   = d_div_reg;
    assign d2_side[0]  = d_side_reg;

    for (genvar k = 0; k < IQ_W; k++)
    begin : g_div2
        csvs_div_stage #(.DW(IDEN_W), .QW(IQ_W), .SW(SIDE2_W)) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .valid_in  (d2_valid[k]),
            .work_in   (d2_work[k]),
            .div_in    (d2_div[k]),
            .side_in   (d2_side[k]),
            .valid_reg (d2_valid[k+1]),
            .work_reg  (d2_work[k+1]),
            .div_reg   (d2_div[k+1]),
            .side_reg  (d2_side[k+1])
        );
    end

    // stage E: apply sign, select angle, output register
    logic [IQ_W-1:0]           quot;
    logic [BREAK_W-1:0]        e_corr;
    logic                      e_floor;
    angle_sel_t                e_sel;
    logic                      e_neg;
    logic [IQ_W:0]             step;
    logic [ANGLE_W-1:0]        angle_now;

    logic signed [ANGLE_W-1:0] angle_reg;
    logic [BREAK_W-1:0]        corr_out_reg;
    logic                      floor_out_reg;

    always_comb
    begin
        quot    = d2_work[IQ_W][IQ_W-1:0];
        e_corr  = d2_side[IQ_W][SIDE2_W-1:4];
        e_floor = d2_side[IQ_W][3];
        e_sel   = angle_sel_t'(d2_side[IQ_W][2:1]);
        e_neg   = d2_side[IQ_W][0];
        step    = e_neg ? (IQ_W+1)'(-{1'b0, quot}) : {1'b0, quot};
        case (e_sel)
            SEL_CLOSED: angle_now = closed_reg;
            SEL_OPEN:   angle_now = open_reg;
            SEL_INTERP: angle_now = ANGLE_W'(closed_reg) + step[ANGLE_W-1:0];
            default:    angle_now = closed_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= d2_valid[IQ_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            angle_reg     <= angle_now;
            corr_out_reg  <= e_corr;
            floor_out_reg <= e_floor;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.vane_angle      = angle_reg;
    assign result.corrected_speed = corr_out_reg;
    assign result.theta_floored   = floor_out_reg;
endmodule

// ===== tb/csvs_schedule_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// csvs_schedule_checker
// Watches the configuration port and both channels of the corrected speed
// vane schedule. Keeps its own copy of the four registers, computes the
// expected angle, corrected speed and floor flag for every accepted sample
// and compares each accepted result against the oldest expectation.
// ----------------------------------------------------------------------------
module csvs_schedule_checker
    import csvs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [IDX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]    cfg_data,
    csvs_sample_if              sample,
    csvs_result_if              result,
    output int                  fail_count,
    output int                  pending
);

    typedef struct packed {
        logic [ANGLE_W-1:0] angle;
        logic [BREAK_W-1:0] speed;
        logic               floored;
    } vane_result_t;

    localparam longint unsigned SCALE = 922080;
    localparam int unsigned CORR_MAX = 524287;

    logic [BREAK_W-1:0]        low_brk;
    logic [BREAK_W-1:0]        high_brk;
    logic signed [ANGLE_W-1:0] closed_ang;
    logic signed [ANGLE_W-1:0] open_ang;

    vane_result_t vane_results_q[$];
    int           mismatches;

    // corrected speed is the largest c with (2c-1)^2 * D <= 4 * S^2 * 922080
    function automatic vane_result_t schedule_vane(logic [SPEED_W-1:0] spd,
                                                   logic [TEMP_W-1:0] temp);
        vane_result_t    r;
        longint unsigned den;
        longint unsigned four_num;
        longint unsigned t;
        int unsigned     lo;
        int unsigned     hi;
        int unsigned     mid;
        longint          span;
        longint          num;
        longint          d;
        longint          mag;
        longint          q;
        longint          ang;
        r.floored = (50 * longint'(temp)) < longint'(REF_DEN_X10);
        den = r.floored ? longint'(REF_DEN_X10) : 50 * longint'(temp);
        four_num = 4 * longint'(spd) * longint'(spd) * SCALE;
        lo = 0;
        hi = CORR_MAX;
        while (lo < hi)
        begin
            mid = lo + (hi - lo + 1) / 2;
            t = 2 * longint'(mid) - 1;
            if (t * t * den <= four_num)
                lo = mid;
            else
                hi = mid - 1;
        end
        r.speed = lo[BREAK_W-1:0];
        if (lo <= low_brk)
            ang = closed_ang;
        else if (lo >= high_brk)
            ang = open_ang;
        else
        begin
            span = longint'(open_ang) - longint'(closed_ang);
            num = span * (longint'(lo) - longint'(low_brk));
            d = longint'(high_brk) - longint'(low_brk);
            mag = num < 0 ? -num : num;
            q = (2 * mag + d) / (2 * d);
            ang = longint'(closed_ang) + (num < 0 ? -q : q);
        end
        r.angle = ang[ANGLE_W-1:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        vane_result_t got;
        vane_result_t want;
        if (!rst_n)
        begin
            low_brk    <= LOW_BREAK_RST;
            high_brk   <= HIGH_BREAK_RST;
            closed_ang <= CLOSED_RST;
            open_ang   <= OPEN_RST;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    REG_LOW_BREAK:  low_brk    <= cfg_data;
                    REG_HIGH_BREAK: high_brk   <= cfg_data;
                    REG_CLOSED:     closed_ang <= cfg_data[ANGLE_W-1:0];
                    REG_OPEN:       open_ang   <= cfg_data[ANGLE_W-1:0];
                    default: ;
                endcase
            end
            if (sample.valid && sample.ready)
                vane_results_q.push_back(schedule_vane(sample.shaft_speed,
                                                       sample.inlet_temp));
            if (result.valid && result.ready)
            begin
                got.angle   = result.vane_angle;
                got.speed   = result.corrected_speed;
                got.floored = result.theta_floored;
                if (vane_results_q.size() == 0)
                begin
                    fail_count++;
                    if (mismatches++ < 10)
                        $display("[%0t] unexpected result transaction: angle %0d speed %0d",
                                 $realtime, $signed(got.angle), got.speed);
                end
                else
                begin
                    want = vane_results_q.pop_front();
                    if (got !== want)
                    begin
                        fail_count++;
                        if (mismatches++ < 10)
                            $display({"[%0t] mismatch: angle %0d/%0d speed %0d/%0d ",
                                      "floored %0d/%0d (expected/actual)"}, $realtime,
                                     $signed(want.angle), $signed(got.angle),
                                     want.speed, got.speed, want.floored, got.floored);
                    end
                end
            end
        end
        pending = vane_results_q.size();
    end

    initial
    begin
        fail_count = 0;
        pending    = 0;
        mismatches = 0;
    end

endmodule

// ===== tb/tb_corrected_speed_vane_schedule_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_corrected_speed_vane_schedule_unit
// Drives directed corner samples and random samples through the vane
// schedule under several register settings, with random gaps on the input
// and random stalls on the output. The checker beside the block predicts
// and compares; this module reports the verdict.
// ----------------------------------------------------------------------------
module tb_corrected_speed_vane_schedule_unit;
    import csvs_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 120;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [IDX_W-1:0]  cfg_index;
    logic [CFG_W-1:0]  cfg_data;
    int                fail_count;
    int                pending;
    int                cycles;
    int                stall_left;
    int                run_left;

    csvs_sample_if sample_ch();
    csvs_result_if result_ch();

    corrected_speed_vane_schedule_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (sample_ch),
        .result    (result_ch)
    );

    csvs_schedule_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .sample     (sample_ch),
        .result     (result_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // mostly short gaps, a few long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAIL corrected_speed_vane_schedule_unit");
            $finish;
        end
    end

    // result stalls, alternating with stretches of steady ready
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            stall_left <= 0;
            run_left <= 0;
        end
        else if (stall_left > 0)
        begin
            result_ch.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (run_left > 0)
        begin
            result_ch.ready <= 1'b1;
            run_left <= run_left - 1;
        end
        else
        begin
            result_ch.ready <= 1'b1;
            stall_left <= gap_len();
            run_left <= $urandom_range(0, 1) ? $urandom_range(1, 4) : $urandom_range(10, 80);
        end
    end

    task automatic send_sample(logic [SPEED_W-1:0] spd, logic [TEMP_W-1:0] temp);
        int gap;
        gap = gap_len();
        if (gap > 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_ch.valid       <= 1'b1;
        sample_ch.shaft_speed <= spd;
        sample_ch.inlet_temp  <= temp;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
    endtask

    task automatic wait_idle();
        sample_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // hold the write enable across all four registers
    task automatic program_regs(logic [CFG_W-1:0] lo_brk, logic [CFG_W-1:0] hi_brk,
                                logic [CFG_W-1:0] closed, logic [CFG_W-1:0] opened);
        cfg_we    <= 1'b1;
        cfg_index <= REG_LOW_BREAK;
        cfg_data  <= lo_brk;
        @(posedge clk);
        cfg_index <= REG_HIGH_BREAK;
        cfg_data  <= hi_brk;
        @(posedge clk);
        cfg_index <= REG_CLOSED;
        cfg_data  <= closed;
        @(posedge clk);
        cfg_index <= REG_OPEN;
        cfg_data  <= opened;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_samples(int count);
        logic [SPEED_W-1:0] spd;
        logic [TEMP_W-1:0]  temp;
        for (int i = 0; i < count; i++)
        begin
            spd = SPEED_W'($urandom);
            case ($urandom_range(0, 3))
                0: temp = TEMP_W'($urandom);
                1: temp = TEMP_W'($urandom_range(0, 2000));
                default: temp = TEMP_W'($urandom_range(14000, 26000));
            endcase
            if ($urandom_range(0, 3) == 0)
                spd = SPEED_W'($urandom_range(0, 20000));
            send_sample(spd, temp);
        end
    endtask

    initial
    begin
        logic [CFG_W-1:0] a;
        logic [CFG_W-1:0] b;
        cycles = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_LOW_BREAK;
        cfg_data = '0;
        sample_ch.valid = 1'b0;
        sample_ch.shaft_speed = '0;
        sample_ch.inlet_temp = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults: field extremes, floor edge, theta of one, breakpoint hits
        send_sample(17'd0, 16'd0);
        send_sample(17'h1FFFF, 16'd0);
        send_sample(17'h1FFFF, 16'hFFFF);
        send_sample(17'd0, 16'hFFFF);
        send_sample(17'd50000, 16'd1844);
        send_sample(17'd50000, 16'd1845);
        send_sample(17'd15000, 16'd18442);
        send_sample(17'd90000, 16'd18442);
        send_sample(17'd52500, 16'd18442);
        send_sample(17'd15001, 16'd18442);
        send_sample(17'd89999, 16'd18442);
        send_sample(17'd1, 16'd1);
        wait_idle();

        // full span, extreme angles with junk above bit 15
        program_regs(19'd0, 19'h7FFFF, 19'h7A600, 19'h05A00);
        send_sample(17'h1FFFF, 16'd0);
        send_sample(17'd1, 16'hFFFF);
        send_sample(17'd65536, 16'd1844);
        send_sample(17'd100000, 16'd30000);
        random_samples(90);
        wait_idle();

        // breakpoints out of order, then equal
        program_regs(19'd60000, 19'd20000, 19'd23040, -19'sd23040);
        send_sample(17'd60000, 16'd18442);
        send_sample(17'd60001, 16'd18442);
        send_sample(17'd19999, 16'd18442);
        random_samples(60);
        wait_idle();
        program_regs(19'd40000, 19'd40000, 19'h7FFFF, 19'h08000);
        send_sample(17'd40000, 16'd18442);
        send_sample(17'd40001, 16'd18442);
        random_samples(50);
        wait_idle();

        // narrow span so rounding halves show up
        program_regs(19'd30000, 19'd30002, 19'd1, 19'd0);
        for (int i = 0; i < 30; i++)
            send_sample(17'($urandom_range(29990, 30010)), 16'd18442);
        wait_idle();

        for (int p = 0; p < 5; p++)
        begin
            a = CFG_W'($urandom_range(0, 120000));
            b = a + CFG_W'($urandom_range(1, 150000));
            program_regs(a, b, CFG_W'($urandom_range(0, 46080) - 23040),
                         CFG_W'($urandom_range(0, 46080) - 23040));
            random_samples(85);
            wait_idle();
        end

        program_regs(19'd15000, 19'd90000, 19'd7680, 19'h7F100);
        random_samples(50);
        wait_idle();

        if (fail_count == 0)
            $display("PASS corrected_speed_vane_schedule_unit");
        else
            $display("FAIL corrected_speed_vane_schedule_unit");
        $finish;
    end

endmodule
